// ----- rtl/efd_pkg.sv -----
// ----------------------------------------------------------------------------
// efd_pkg
// Shared types and constants for the escaped frame deframer.
// ----------------------------------------------------------------------------
package efd_pkg;

  localparam int unsigned MaxPayloadDef   = 15;
  localparam int unsigned RecvBufBytesDef = 32;

  localparam logic [7:0]  StartByte   = 8'hFD;
  localparam logic [7:0]  EscapeByte  = 8'hFC;
  localparam logic [7:0]  EscapeMask  = 8'h80;
  localparam logic [15:0] CrcPolyRst  = 16'h8408;

  localparam int unsigned CrcBits = 8;
  localparam int unsigned CrcCntW = $clog2(CrcBits);

  typedef enum logic [1:0] {
    KindToken   = 2'd0,
    KindHeader  = 2'd1,
    KindPayload = 2'd2,
    KindError   = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    SeqIdle = 5'b00001,
    SeqCrc  = 5'b00010,
    SeqEval = 5'b00100,
    SeqHead = 5'b01000,
    SeqData = 5'b10000
  } seq_e;

  typedef enum logic [3:0] {
    PhSync   = 4'b0001,
    PhHeader = 4'b0010,
    PhPacket = 4'b0100,
    PhCrc    = 4'b1000
  } phase_e;

  typedef struct packed {
    logic       start;
    logic       seed_zero;
    logic [7:0] data;
  } crc_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } crc_sts_t;

  typedef struct packed {
    kind_e      kind;
    logic [5:0] destination;
    logic       broadcast;
    logic [5:0] source;
    logic [1:0] sequence_res;
    logic [3:0] command;
    logic [3:0] payload_length;
    logic [7:0] payload_byte;
    logic       last;
  } res_t;

endpackage

// ----- rtl/efd_crc_unit.sv -----
// ----------------------------------------------------------------------------
// efd_crc_unit
// Bit-serial reflected CRC-16: a byte is XORed into the low end of the register and then shifted through bit by bit.
// ----------------------------------------------------------------------------
module efd_crc_unit import efd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] poly_i,
  input  crc_cmd_t    cmd_i,
  output crc_sts_t    sts_o,
  output logic [15:0] crc_o
);

  logic [15:0]        crc_q, crc_d;
  logic [CrcCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               last_bit;

  assign last_bit = (cnt_q == CrcCntW'(CrcBits - 1));

  always_comb begin
    crc_d  = crc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (cmd_i.start) begin
      crc_d  = (cmd_i.seed_zero ? 16'h0000 : crc_q) ^ {8'h00, cmd_i.data};
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      crc_d = crc_q[0] ? ((crc_q >> 1) ^ poly_i) : (crc_q >> 1);
      cnt_d = cnt_q + CrcCntW'(1);
      if (last_bit) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = busy_q && last_bit;
  assign crc_o      = crc_q;

endmodule

// ----- rtl/efd_payload_buf.sv -----
// ----------------------------------------------------------------------------
// efd_payload_buf
// Payload byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module efd_payload_buf #(
  parameter int unsigned Depth = 15,
  parameter int unsigned IdxW  = 4
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  logic [7:0]      wr_data_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output logic [7:0]      rd_data_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/escaped_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// escaped_frame_deframer
// Byte-stuffed serial frame receiver with a CRC-16 check.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o, wire_byte_i): one raw line byte per
// transfer. Escape bytes and bytes seen while out of sync are taken without
// leaving the idle state. Any other byte goes through the bit-serial CRC unit:
// it is accepted, folded into the CRC and then decoded before the block is
// ready again; a start byte skips the decode step.
// Output channel (out_valid_o/out_ready_i): one result per transfer, held in
// an output register. A token, an error, or a good frame's header and payload
// bytes leave at one result per cycle while the receiver takes them; the first
// result is registered once the byte that ends the frame has been decoded. A
// full 15-byte frame ends in a burst of 16 results. A stalled receiver holds
// the burst in place and the input stays not ready until the burst has been
// loaded. A single result left waiting does not block the next input
// transfer.
// Config channel (cfg_valid_i/cfg_ready_o, cfg_data_i): CRC polynomial, always
// ready; write it only while idle.
// Reset: parser out of sync, no escape pending, polynomial 0x8408, no result.
// ----------------------------------------------------------------------------
module escaped_frame_deframer import efd_pkg::*; #(
  parameter int unsigned MaxPayload   = MaxPayloadDef,
  parameter int unsigned RecvBufBytes = RecvBufBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  wire_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [5:0]  destination_o,
  output logic        broadcast_o,
  output logic [5:0]  source_o,
  output logic [1:0]  sequence_res_o,
  output logic [3:0]  command_o,
  output logic [3:0]  payload_length_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_o
);

  localparam int unsigned IdxW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam int unsigned BcW  = $clog2(RecvBufBytes + 1);

  seq_e            seq_q, seq_d;
  phase_e          phase_q, phase_d;
  logic            esc_q, esc_d;
  logic [BcW-1:0]  bc_q, bc_d;
  logic            start_q, start_d;
  logic [7:0]      hs0_q, hs0_d, hs1_q, hs1_d, hs2_q, hs2_d;
  logic [3:0]      fl_q, fl_d;
  kind_e           rkind_q, rkind_d;
  logic [IdxW-1:0] emit_idx_q, emit_idx_d;
  logic [15:0]     poly_q;
  logic            out_valid_q, out_valid_d;
  res_t            res_q, res_d;

  crc_cmd_t        crc_cmd;
  crc_sts_t        crc_sts;
  logic [15:0]     crc_val;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [7:0]      byte_q, byte_d;
  logic [7:0]      rd_data;
  logic            slot_free;

  efd_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .poly_i (poly_q),
    .cmd_i  (crc_cmd),
    .sts_o  (crc_sts),
    .crc_o  (crc_val)
  );

  efd_payload_buf #(
    .Depth (MaxPayload),
    .IdxW  (IdxW)
  ) u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (byte_q),
    .rd_addr_i (emit_idx_d),
    .rd_data_o (rd_data)
  );

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (seq_q == SeqIdle);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    logic [7:0] c;
    logic [7:0] bc8;
    logic [7:0] pidx;
    logic [3:0] fl_new;
    logic       with_cmd;

    seq_d       = seq_q;
    phase_d     = phase_q;
    esc_d       = esc_q;
    bc_d        = bc_q;
    start_d     = start_q;
    byte_d      = byte_q;
    hs0_d       = hs0_q;
    hs1_d       = hs1_q;
    hs2_d       = hs2_q;
    fl_d        = fl_q;
    rkind_d     = rkind_q;
    emit_idx_d  = emit_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_d       = res_q;
    crc_cmd     = '0;
    wr_en       = 1'b0;

    c        = esc_q ? (wire_byte_i | EscapeMask) : wire_byte_i;
    bc8      = 8'(bc_q);
    pidx     = bc8 - 8'd5;
    wr_addr  = pidx[IdxW-1:0];
    fl_new   = byte_q[3:0];
    with_cmd = (rkind_q != KindToken);

    case (seq_q)
      SeqIdle: begin
        if (in_valid_i) begin
          if (wire_byte_i == EscapeByte) begin
            esc_d = 1'b1;
          end else begin
            esc_d = 1'b0;
            if (wire_byte_i == StartByte) begin
              phase_d           = PhHeader;
              bc_d              = BcW'(1);
              start_d           = 1'b1;
              byte_d            = c;
              crc_cmd.start     = 1'b1;
              crc_cmd.seed_zero = 1'b1;
              crc_cmd.data      = c;
              seq_d             = SeqCrc;
            end else if (phase_q != PhSync) begin
              bc_d          = bc_q + BcW'(1);
              start_d       = 1'b0;
              byte_d        = c;
              crc_cmd.start = 1'b1;
              crc_cmd.data  = c;
              seq_d         = SeqCrc;
            end
          end
        end
      end
      SeqCrc: begin
        if (crc_sts.done) begin
          seq_d = start_q ? SeqIdle : SeqEval;
        end
      end
      SeqEval: begin
        seq_d = SeqIdle;
        if (32'(bc_q) >= RecvBufBytes) begin
          phase_d = PhSync;
          bc_d    = '0;
        end else begin
          case (phase_q)
            PhHeader: begin
              if (bc8 == 8'd2) begin
                hs0_d = byte_q;
              end else begin
                hs1_d = byte_q;
                if (!hs0_q[0]) begin
                  rkind_d = KindToken;
                  phase_d = PhSync;
                  bc_d    = '0;
                  seq_d   = SeqHead;
                end else begin
                  phase_d = PhPacket;
                end
              end
            end
            PhPacket: begin
              if (bc8 == 8'd4) begin
                hs2_d = byte_q;
                fl_d  = fl_new;
                if (32'(fl_new) > MaxPayload) begin
                  phase_d = PhSync;
                  bc_d    = '0;
                end else if (fl_new == 4'd0) begin
                  phase_d = PhCrc;
                end
              end else begin
                wr_en = (32'(pidx) < MaxPayload);
                if (bc8 == 8'(fl_q) + 8'd4) begin
                  phase_d = PhCrc;
                end
              end
            end
            PhCrc: begin
              if (bc8 == 8'(fl_q) + 8'd6) begin
                phase_d = PhSync;
                bc_d    = '0;
                rkind_d = (crc_val != 16'h0000) ? KindError : KindHeader;
                seq_d   = SeqHead;
              end
            end
            default: begin
              phase_d = PhSync;
              bc_d    = '0;
            end
          endcase
        end
      end
      SeqHead: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          res_d.kind           = rkind_q;
          res_d.destination    = hs0_q[7:2];
          res_d.broadcast      = hs0_q[1];
          res_d.source         = hs1_q[7:2];
          res_d.sequence_res   = hs1_q[1:0];
          res_d.command        = with_cmd ? hs2_q[7:4] : 4'd0;
          res_d.payload_length = with_cmd ? hs2_q[3:0] : 4'd0;
          res_d.payload_byte   = 8'd0;
          res_d.last           = (rkind_q != KindHeader) || (fl_q == 4'd0);
          seq_d = ((rkind_q == KindHeader) && (fl_q != 4'd0)) ? SeqData : SeqIdle;
        end
      end
      SeqData: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          res_d.kind           = KindPayload;
          res_d.payload_byte   = rd_data;
          res_d.last           = (5'(emit_idx_q) + 5'd1 == {1'b0, fl_q});
          if (res_d.last) begin
            emit_idx_d = '0;
            seq_d      = SeqIdle;
          end else begin
            emit_idx_d = emit_idx_q + IdxW'(1);
          end
        end
      end
      default: begin
        seq_d = SeqIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SeqIdle;
      phase_q     <= PhSync;
      esc_q       <= 1'b0;
      bc_q        <= '0;
      start_q     <= 1'b0;
      fl_q        <= '0;
      rkind_q     <= KindToken;
      emit_idx_q  <= '0;
      poly_q      <= CrcPolyRst;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      phase_q     <= phase_d;
      esc_q       <= esc_d;
      bc_q        <= bc_d;
      start_q     <= start_d;
      fl_q        <= fl_d;
      rkind_q     <= rkind_d;
      emit_idx_q  <= emit_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        poly_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    hs0_q  <= hs0_d;
    hs1_q  <= hs1_d;
    hs2_q  <= hs2_d;
    res_q  <= res_d;
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = res_q.kind;
  assign destination_o    = res_q.destination;
  assign broadcast_o      = res_q.broadcast;
  assign source_o         = res_q.source;
  assign sequence_res_o   = res_q.sequence_res;
  assign command_o        = res_q.command;
  assign payload_length_o = res_q.payload_length;
  assign payload_byte_o   = res_q.payload_byte;
  assign last_o           = res_q.last;

`ifndef SYNTHESIS
  a_accept_crc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !crc_sts.busy)
    else $error("input transfer while CRC unit busy");

  a_emit_idx_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q != SeqData) |-> (emit_idx_q == '0))
    else $error("payload cursor not parked outside a burst");

  a_burst_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SeqData) |-> ((fl_q != 4'd0) && (32'(fl_q) <= MaxPayload)))
    else $error("payload burst with bad length");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SeqIdle) |-> (32'(bc_q) < RecvBufBytes))
    else $error("byte count at buffer limit while idle");

  a_crc_done_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_sts.done |=> ((seq_q == SeqEval) || (seq_q == SeqIdle)))
    else $error("sequencer missed CRC completion");
`endif

endmodule
